// ===== src/gif_lzw_encoder_unit_defines.svh =====
// Assertion macros shared by the checker of the GIF LZW encoder.
// Depends on nothing; included by the checker file.
`ifndef GIF_LZW_ENCODER_UNIT_DEFINES_SVH
`define GIF_LZW_ENCODER_UNIT_DEFINES_SVH

// Concurrent assertion, quiet while reset is high
`define GLZW_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset
`define GLZW_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/glzw_pkg.sv =====
// Types, constants and helper functions of the GIF LZW encoder.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package glzw_pkg;

   // Dictionary geometry
   localparam int HASH_SLOTS    = 5003;
   localparam int MAX_CODE_BITS = 12;
   localparam int SLOT_AW       = $clog2(HASH_SLOTS);
   localparam int CODE_W        = MAX_CODE_BITS;
   localparam int KEY_W         = 8 + MAX_CODE_BITS;
   localparam int SLOT_W        = KEY_W + CODE_W;
   localparam int FREE_W        = MAX_CODE_BITS + 1;

   // Bit packer
   localparam int ACC_W  = 24;
   localparam int HELD_W = 5;

   // Starting code width limits and clear code width
   localparam logic [3:0] INIT_BITS_MIN   = 4'd3;
   localparam logic [3:0] INIT_BITS_MAX   = 4'd9;
   localparam logic [3:0] INIT_BITS_RESET = 4'd9;
   localparam int         CC_W            = 9;

   // Register addresses
   localparam logic [1:0] ADDR_INIT_BITS = 2'd0;

   localparam logic [FREE_W-1:0] TABLE_FULL = FREE_W'(1) << MAX_CODE_BITS;

   // Shift of the pixel in the xor hash
   function automatic int hash_shift_f();
      int     n;
      longint f;
      n = 0;
      f = HASH_SLOTS;
      while (f < 65536) begin
         f = f * 2;
         n = n + 1;
      end
      return (n < 8) ? 8 - n : 0;
   endfunction

   localparam int HASH_SHIFT = hash_shift_f();
   localparam int HASH_W     = (8 + HASH_SHIFT > CODE_W) ? 8 + HASH_SHIFT : CODE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PACK,
      ST_BYTES,
      ST_DRAIN,
      ST_SWEEP
   } st_type;

   typedef enum logic [1:0] {
      STEP_MAIN,
      STEP_FULL,
      STEP_LASTP,
      STEP_END
   } step_type;

   // First slot of a key: xor hash folded once into the table
   function automatic logic [SLOT_AW-1:0] hash_index(input logic [7:0]        c,
                                                      input logic [CODE_W-1:0] prefix);
      logic [HASH_W:0] h;
      h = ((HASH_W+1)'(c) << HASH_SHIFT) ^ (HASH_W+1)'(prefix);
      if (h >= (HASH_W+1)'(HASH_SLOTS)) begin
         h = h - (HASH_W+1)'(HASH_SLOTS);
      end
      return SLOT_AW'(h);
   endfunction

endpackage

`default_nettype wire

// ===== src/glzw_if.sv =====
// Word channels of the GIF LZW encoder: pixel requests and code bytes.
// Depends on nothing.
`default_nettype none

interface glzw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_index;
   logic       last_pixel;
   modport source (output valid, pixel_index, last_pixel, input ready);
   modport sink   (input valid, pixel_index, last_pixel, output ready);
endinterface

interface glzw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       end_of_run;
   logic       end_of_stream;
   modport source (output valid, code_byte, end_of_run, end_of_stream, input ready);
   modport sink   (input valid, code_byte, end_of_run, end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== src/gif_lzw_encoder_unit.sv =====
// GIF LZW encoder top level: sequencer, hash dictionary lookup and bit packer.
// Depends on glzw_pkg, glzw_req_if / glzw_rsp_if and glzw_ram.
//
// Usage:
//   req_ch carries one pixel index per word, last_pixel set on the final
//   pixel of an image. rsp_ch carries the packed code stream, one byte per
//   word; end_of_run marks the last byte caused by a pixel and end_of_stream
//   the last byte of the image. The csr_ APB port holds initial_code_bits.
//   Pixels are taken one at a time. A pixel whose key is found in the
//   dictionary sends no code unless it is the last pixel; each further
//   probe of the hash table stays in ST_CHECK for another read, since
//   the dictionary is a single RAM read once per cycle.
//   A miss runs ST_PACK and then ST_BYTES for each code it sends.
//   The first pixel of an image and every dictionary reset start a clearing
//   pass over all 5003 slots, one slot a cycle, during which no pixel is taken.
//   Reset puts the block back to wait for the first pixel of an image and
//   sets initial_code_bits to 9; the RAM needs no clearing pass at reset.
//   A stalled receiver holds the current byte in the output register; the
//   next byte waits in a one-word stage and the sequencer holds behind it.
`default_nettype none

module gif_lzw_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   glzw_req_if.sink         req_ch,
   glzw_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int AW = glzw_pkg::SLOT_AW;
   localparam int CW = glzw_pkg::CODE_W;
   localparam int FW = glzw_pkg::FREE_W;
   localparam int AC = glzw_pkg::ACC_W;
   localparam int HW = glzw_pkg::HELD_W;
   localparam int KW = glzw_pkg::KEY_W;
   localparam int CC = glzw_pkg::CC_W;

   glzw_pkg::st_type   state_ff, state_in;
   glzw_pkg::step_type step_ff, step_in;

   logic [3:0]    csr_bits_ff, lat_bits_ff, lat_bits_in;
   logic [CW-1:0] prefix_ff, prefix_in, code_ff, code_in;
   logic [FW-1:0] nf_ff, nf_in, lim_ff, lim_in;
   logic [3:0]    cw_ff, cw_in;
   logic          cp_ff, cp_in;
   logic [AC-1:0] acc_ff, acc_in;
   logic [HW-1:0] held_ff, held_in;
   logic          await_ff, await_in;
   logic [7:0]    c_ff, c_in;
   logic          last_ff, last_in;
   logic [KW-1:0] key_ff, key_in;
   logic [AW-1:0] idx_ff, idx_in, disp_ff, disp_in, tries_ff, tries_in;
   logic [AW-1:0] swp_ff, swp_in;
   logic          miss_ff, miss_in, slot_ff, slot_in, full_ff, full_in;
   logic          sweep_ff, sweep_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_eor_ff, out_eor_in, out_eos_ff, out_eos_in;

   // RAM ports
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [glzw_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;

   // Combinational helpers
   logic [CC-1:0] cc, cc_new;
   logic [3:0]    b_new;
   logic [7:0]    c_req;
   logic [AW-1:0] h_req, nxt_idx;
   logic [AW:0]   nxt_sum;
   logic [CW-1:0] rd_code;
   logic [KW-1:0] rd_key;
   logic [AC-1:0] acc_pack;
   logic [CW-1:0] code_mask;
   logic [3:0]    cw_up;
   logic          out_free, can_push, have_byte;

   glzw_ram #(
      .WIDTH (glzw_pkg::SLOT_W),
      .DEPTH (glzw_pkg::HASH_SLOTS)
   ) u_dict (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == glzw_pkg::ADDR_INIT_BITS) ? {28'd0, csr_bits_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bits_ff <= glzw_pkg::INIT_BITS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == glzw_pkg::ADDR_INIT_BITS) begin
         csr_bits_ff <= csr_pwdata[3:0];
      end
   end

   // Channel ports
   assign req_ch.ready         = (state_ff == glzw_pkg::ST_IDLE);
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.code_byte     = out_byte_ff;
   assign rsp_ch.end_of_run    = out_eor_ff;
   assign rsp_ch.end_of_stream = out_eos_ff;

   // Derived values
   always_comb begin
      cc     = CC'(1) << (lat_bits_ff - 4'd1);
      b_new  = (csr_bits_ff < glzw_pkg::INIT_BITS_MIN) ? glzw_pkg::INIT_BITS_MIN :
               (csr_bits_ff > glzw_pkg::INIT_BITS_MAX) ? glzw_pkg::INIT_BITS_MAX : csr_bits_ff;
      cc_new = CC'(1) << (b_new - 4'd1);
      c_req  = req_ch.pixel_index & 8'(cc - CC'(1));
      h_req  = glzw_pkg::hash_index(c_req, prefix_ff);
      rd_code = ram_rdata[CW-1:0];
      rd_key  = ram_rdata[glzw_pkg::SLOT_W-1:CW];
      // Secondary probe: step back by the displacement, wrap into the table
      if (idx_ff >= disp_ff) begin
         nxt_sum = {1'b0, idx_ff} - {1'b0, disp_ff};
      end else begin
         nxt_sum = {1'b0, idx_ff} + (AW+1)'(glzw_pkg::HASH_SLOTS) - {1'b0, disp_ff};
      end
      nxt_idx   = nxt_sum[AW-1:0];
      code_mask = (CW'(1) << cw_ff) - CW'(1);
      acc_pack  = (acc_ff & ((AC'(1) << held_ff) - AC'(1))) |
                  (AC'(code_ff & code_mask) << held_ff);
      cw_up     = cw_ff + 4'd1;
      out_free  = !out_valid_ff || rsp_ch.ready;
      can_push  = !pend_valid_ff || out_free;
      have_byte = (held_ff >= HW'(8)) || (step_ff == glzw_pkg::STEP_END && held_ff != '0);
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      lat_bits_in   = lat_bits_ff;
      prefix_in     = prefix_ff;
      code_in       = code_ff;
      nf_in         = nf_ff;
      lim_in        = lim_ff;
      cw_in         = cw_ff;
      cp_in         = cp_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      await_in      = await_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      disp_in       = disp_ff;
      tries_in      = tries_ff;
      swp_in        = swp_ff;
      miss_in       = miss_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      sweep_in      = sweep_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_eor_in    = out_eor_ff;
      out_eos_in    = out_eos_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = {key_ff, nf_ff[CW-1:0]};
      ram_raddr     = idx_ff;

      // Drop the output word once taken
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         glzw_pkg::ST_IDLE: begin
            ram_raddr = h_req;
            if (req_ch.valid) begin
               last_in  = req_ch.last_pixel;
               await_in = req_ch.last_pixel;
               full_in  = 1'b0;
               miss_in  = 1'b0;
               tries_in = '0;
               if (await_ff) begin
                  // Start of image: latch width, send a clear code, clear afterwards
                  lat_bits_in = b_new;
                  cw_in       = b_new;
                  lim_in      = (FW'(1) << b_new) - FW'(1);
                  nf_in       = FW'(cc_new) + FW'(2);
                  cp_in       = 1'b0;
                  acc_in      = '0;
                  held_in     = '0;
                  sweep_in    = 1'b1;
                  prefix_in   = CW'(req_ch.pixel_index & 8'(cc_new - CC'(1)));
                  code_in     = CW'(cc_new);
                  step_in     = glzw_pkg::STEP_MAIN;
                  state_in    = glzw_pkg::ST_PACK;
               end else begin
                  c_in     = c_req;
                  key_in   = {c_req, prefix_ff};
                  idx_in   = h_req;
                  disp_in  = (h_req == '0) ? AW'(1) : AW'(glzw_pkg::HASH_SLOTS) - h_req;
                  state_in = glzw_pkg::ST_CHECK;
               end
            end
         end

         glzw_pkg::ST_CHECK: begin
            if (rd_code == '0 || (rd_key != key_ff && tries_ff == AW'(glzw_pkg::HASH_SLOTS))) begin
               // Miss: send the prefix, record the key when there is room
               slot_in   = (rd_code == '0);
               miss_in   = 1'b1;
               code_in   = prefix_ff;
               prefix_in = CW'(c_ff);
               step_in   = glzw_pkg::STEP_MAIN;
               state_in  = glzw_pkg::ST_PACK;
            end else if (rd_key == key_ff) begin
               // Hit: extend the prefix
               prefix_in = rd_code;
               if (last_ff) begin
                  code_in  = rd_code;
                  step_in  = glzw_pkg::STEP_LASTP;
                  state_in = glzw_pkg::ST_PACK;
               end else begin
                  state_in = glzw_pkg::ST_DRAIN;
               end
            end else begin
               // Collision: advance to the next probe slot
               idx_in    = nxt_idx;
               ram_raddr = nxt_idx;
               tries_in  = tries_ff + AW'(1);
            end
         end

         glzw_pkg::ST_PACK: begin
            acc_in  = acc_pack;
            held_in = held_ff + HW'(cw_ff);
            // Grow the code width, or restore it after a clear code
            if (nf_ff > lim_ff || cp_ff) begin
               if (cp_ff) begin
                  cw_in  = lat_bits_ff;
                  lim_in = (FW'(1) << lat_bits_ff) - FW'(1);
                  cp_in  = 1'b0;
               end else if (cw_ff < 4'(glzw_pkg::MAX_CODE_BITS)) begin
                  cw_in  = cw_up;
                  lim_in = (cw_up == 4'(glzw_pkg::MAX_CODE_BITS)) ?
                           glzw_pkg::TABLE_FULL : (FW'(1) << cw_up) - FW'(1);
               end
            end
            // Dictionary update that follows the prefix of a miss
            if (step_ff == glzw_pkg::STEP_MAIN && miss_ff) begin
               if (nf_ff < glzw_pkg::TABLE_FULL) begin
                  if (slot_ff) begin
                     ram_we = 1'b1;
                     nf_in  = nf_ff + FW'(1);
                  end
               end else begin
                  nf_in    = FW'(cc) + FW'(2);
                  cp_in    = 1'b1;
                  full_in  = 1'b1;
                  sweep_in = 1'b1;
               end
            end
            state_in = glzw_pkg::ST_BYTES;
         end

         glzw_pkg::ST_BYTES: begin
            if (have_byte) begin
               // Push one byte through the holding stage
               if (can_push) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_byte_in  = pend_byte_ff;
                     out_eor_in   = 1'b0;
                     out_eos_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_byte_in  = acc_ff[7:0];
                  acc_in        = acc_ff >> 8;
                  held_in       = (held_ff >= HW'(8)) ? held_ff - HW'(8) : '0;
               end
            end else begin
               priority case (step_ff)
                  glzw_pkg::STEP_MAIN: begin
                     if (full_ff) begin
                        code_in  = CW'(cc);
                        step_in  = glzw_pkg::STEP_FULL;
                        state_in = glzw_pkg::ST_PACK;
                     end else if (last_ff) begin
                        code_in  = prefix_ff;
                        step_in  = glzw_pkg::STEP_LASTP;
                        state_in = glzw_pkg::ST_PACK;
                     end else begin
                        state_in = glzw_pkg::ST_DRAIN;
                     end
                  end
                  glzw_pkg::STEP_FULL: begin
                     if (last_ff) begin
                        code_in  = prefix_ff;
                        step_in  = glzw_pkg::STEP_LASTP;
                        state_in = glzw_pkg::ST_PACK;
                     end else begin
                        state_in = glzw_pkg::ST_DRAIN;
                     end
                  end
                  glzw_pkg::STEP_LASTP: begin
                     code_in  = CW'(cc) + CW'(1);
                     step_in  = glzw_pkg::STEP_END;
                     state_in = glzw_pkg::ST_PACK;
                  end
                  default: begin
                     acc_in   = '0;
                     held_in  = '0;
                     state_in = glzw_pkg::ST_DRAIN;
                  end
               endcase
            end
         end

         glzw_pkg::ST_DRAIN: begin
            // Release the held byte as the last of this pixel
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_byte_in   = pend_byte_ff;
                  out_eor_in    = 1'b1;
                  out_eos_in    = last_ff;
                  pend_valid_in = 1'b0;
               end
               if (sweep_ff) begin
                  sweep_in = 1'b0;
                  swp_in   = '0;
                  state_in = glzw_pkg::ST_SWEEP;
               end else begin
                  state_in = glzw_pkg::ST_IDLE;
               end
            end
         end

         glzw_pkg::ST_SWEEP: begin
            // Clear one dictionary slot a cycle
            ram_we    = 1'b1;
            ram_waddr = swp_ff;
            ram_wdata = '0;
            if (swp_ff == AW'(glzw_pkg::HASH_SLOTS - 1)) begin
               state_in = glzw_pkg::ST_IDLE;
            end else begin
               swp_in = swp_ff + AW'(1);
            end
         end

         default: begin
            state_in = glzw_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= glzw_pkg::ST_IDLE;
         step_ff       <= glzw_pkg::STEP_MAIN;
         lat_bits_ff   <= glzw_pkg::INIT_BITS_RESET;
         prefix_ff     <= '0;
         nf_ff         <= '0;
         lim_ff        <= '0;
         cw_ff         <= '0;
         cp_ff         <= 1'b0;
         acc_ff        <= '0;
         held_ff       <= '0;
         await_ff      <= 1'b1;
         miss_ff       <= 1'b0;
         full_ff       <= 1'b0;
         sweep_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         lat_bits_ff   <= lat_bits_in;
         prefix_ff     <= prefix_in;
         nf_ff         <= nf_in;
         lim_ff        <= lim_in;
         cw_ff         <= cw_in;
         cp_ff         <= cp_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         await_ff      <= await_in;
         miss_ff       <= miss_in;
         full_ff       <= full_in;
         sweep_ff      <= sweep_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      c_ff         <= c_in;
      last_ff      <= last_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      disp_ff      <= disp_in;
      tries_ff     <= tries_in;
      swp_ff       <= swp_in;
      slot_ff      <= slot_in;
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_eor_ff   <= out_eor_in;
      out_eos_ff   <= out_eos_in;
   end

endmodule

`default_nettype wire

// ===== src/glzw_ram.sv =====
// Generic simple dual port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module glzw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/glzw_checker.sv =====
// Port-level checker of the GIF LZW encoder, bound to the top level.
// Depends on gif_lzw_encoder_unit_defines.svh and gif_lzw_encoder_unit.
`default_nettype none
`include "gif_lzw_encoder_unit_defines.svh"

module glzw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_code_byte,
   input wire logic       rsp_end_of_run,
   input wire logic       rsp_end_of_stream
);

   // No byte is offered right after reset
   `GLZW_ASSERT(a_reset_quiet, clock, reset |=> !rsp_valid, "byte offered after reset")

   // A stalled byte stays offered and unchanged
   `GLZW_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "byte dropped")
   `GLZW_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_code_byte) && $stable(rsp_end_of_run) && $stable(rsp_end_of_stream), "stalled byte changed")

   // The last byte of an image also closes its pixel
   `GLZW_ASSERT_RST(a_eos_eor, clock, reset, rsp_valid && rsp_end_of_stream |-> rsp_end_of_run, "end of stream without end of run")

   // One pixel at a time: ready drops after a word is taken
   `GLZW_ASSERT_RST(a_one_pixel, clock, reset, req_valid && req_ready |=> !req_ready, "pixel taken while busy")

endmodule

bind gif_lzw_encoder_unit glzw_checker u_glzw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_code_byte     (rsp_ch.code_byte),
   .rsp_end_of_run    (rsp_ch.end_of_run),
   .rsp_end_of_stream (rsp_ch.end_of_stream)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench of the GIF LZW encoder: random images of pixel words in, code bytes checked.
// Depends on glzw_pkg, glzw_req_if / glzw_rsp_if and gif_lzw_encoder_unit.
`timescale 1ns / 1ps

typedef struct {
   logic [7:0] code_byte;
   logic       end_of_run;
   logic       end_of_stream;
} code_word_type;

class lzw_scoreboard;
   code_word_type pending_bytes[$];
   int          errors;
   // predictor state
   logic [3:0]  init_bits_reg;
   int unsigned base_bits;
   logic [11:0] dict_code[glzw_pkg::HASH_SLOTS];
   logic [19:0] dict_key[glzw_pkg::HASH_SLOTS];
   int unsigned prefix, free_code, width, width_limit;
   bit          clear_pending, first_pixel;
   int unsigned acc, held;
   logic [7:0]  step_bytes[$];

   function new();
      errors = 0;
      init_bits_reg = 4'd9;
      base_bits = 9;
      wipe_dict();
      prefix = 0; free_code = 0; width = 0; width_limit = 0;
      clear_pending = 0; first_pixel = 1; acc = 0; held = 0;
   endfunction

   function void wipe_dict();
      foreach (dict_code[k]) begin
         dict_code[k] = '0;
         dict_key[k] = '0;
      end
   endfunction

   function void set_init_bits(logic [3:0] v);
      init_bits_reg = v;
   endfunction

   function int unsigned clear_code();
      return 1 << (base_bits - 1);
   endfunction

   function int unsigned pixel_shift();
      int unsigned n;
      int unsigned f;
      n = 0;
      f = glzw_pkg::HASH_SLOTS;
      while (f < 65536) begin
         f = f * 2;
         n++;
      end
      return (n < 8) ? 8 - n : 0;
   endfunction

   // Pack one code LSB first, then grow or reset the width
   function void pack_code(int unsigned code, bit is_end);
      acc &= (1 << held) - 1;
      acc |= (code & ((1 << width) - 1)) << held;
      held += width;
      while (held >= 8) begin
         step_bytes.push_back(acc[7:0]);
         acc >>= 8;
         held -= 8;
      end
      if (free_code > width_limit || clear_pending) begin
         if (clear_pending) begin
            width = base_bits;
            width_limit = (1 << width) - 1;
            clear_pending = 0;
         end else if (width < glzw_pkg::MAX_CODE_BITS) begin
            width++;
            width_limit = (width == glzw_pkg::MAX_CODE_BITS) ? (1 << glzw_pkg::MAX_CODE_BITS)
                                                              : ((1 << width) - 1);
         end
      end
      if (is_end) begin
         while (held > 0) begin
            step_bytes.push_back(acc[7:0]);
            acc >>= 8;
            held = (held > 8) ? held - 8 : 0;
         end
         acc = 0;
         held = 0;
      end
   endfunction

   // Predict the bytes caused by one accepted pixel word
   function void note_pixel(logic [7:0] pix, bit last);
      int unsigned c, key, b;
      int          i, disp, tries;
      bit          hit, have_slot;
      code_word_type w;
      step_bytes.delete();
      if (first_pixel) begin
         b = init_bits_reg;
         if (b < 3) b = 3;
         if (b > 9) b = 9;
         base_bits = b;
         width = b;
         width_limit = (1 << b) - 1;
         free_code = clear_code() + 2;
         clear_pending = 0;
         acc = 0;
         held = 0;
         wipe_dict();
         prefix = pix & (clear_code() - 1);
         pack_code(clear_code(), 0);
         first_pixel = 0;
      end else begin
         c = pix & (clear_code() - 1);
         key = (c << glzw_pkg::MAX_CODE_BITS) + prefix;
         i = ((c << pixel_shift()) ^ prefix) % glzw_pkg::HASH_SLOTS;
         hit = 0;
         have_slot = 1;
         if (dict_code[i] != 0) begin
            if (dict_key[i] == key) begin
               hit = 1;
            end else begin
               disp = (i == 0) ? 1 : glzw_pkg::HASH_SLOTS - i;
               tries = 0;
               have_slot = 0;
               while (tries < glzw_pkg::HASH_SLOTS) begin
                  tries++;
                  i -= disp;
                  if (i < 0) i += glzw_pkg::HASH_SLOTS;
                  if (dict_code[i] == 0) begin
                     have_slot = 1;
                     break;
                  end
                  if (dict_key[i] == key) begin
                     hit = 1;
                     break;
                  end
               end
            end
         end
         if (hit) begin
            prefix = dict_code[i];
         end else begin
            pack_code(prefix, 0);
            prefix = c;
            if (free_code < (1 << glzw_pkg::MAX_CODE_BITS)) begin
               if (have_slot) begin
                  dict_code[i] = free_code[11:0];
                  dict_key[i] = key[19:0];
                  free_code++;
               end
            end else begin
               wipe_dict();
               free_code = clear_code() + 2;
               clear_pending = 1;
               pack_code(clear_code(), 0);
            end
         end
      end
      if (last) begin
         pack_code(prefix, 0);
         pack_code(clear_code() + 1, 1);
         first_pixel = 1;
      end
      foreach (step_bytes[k]) begin
         w.code_byte = step_bytes[k];
         w.end_of_run = (k == step_bytes.size() - 1);
         w.end_of_stream = w.end_of_run && last;
         pending_bytes.push_back(w);
      end
   endfunction

   task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Compare one accepted byte word against the oldest prediction
   task check_byte(logic [7:0] cb, logic eor, logic eos);
      code_word_type w;
      if (pending_bytes.size() == 0) begin
         report($sformatf("unexpected byte %02h", cb));
      end else begin
         w = pending_bytes.pop_front();
         if (cb !== w.code_byte)
            report($sformatf("code_byte %02h, want %02h", cb, w.code_byte));
         if (eor !== w.end_of_run)
            report($sformatf("end_of_run %b, want %b", eor, w.end_of_run));
         if (eos !== w.end_of_stream)
            report($sformatf("end_of_stream %b, want %b", eos, w.end_of_stream));
      end
   endtask
endclass

module tb_top;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int IDLE_SETTLE    = 40;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          rsp_steady = 0;
   int          quiet_cycles = 0;
   int          sent_pixels = 0;
   lzw_scoreboard sb;

   glzw_req_if req_if ();
   glzw_rsp_if rsp_if ();

   gif_lzw_encoder_unit u_top (
      .clock(clock), .reset(reset), .req_ch(req_if), .rsp_ch(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Toggle the receiver between steady and stalling stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) rsp_steady = ~rsp_steady;
      if (reset) rsp_if.ready = 0;
      else if (rsp_steady) rsp_if.ready = 1;
      else if ($urandom_range(0, 99) < 3) rsp_if.ready = 0;
      else if (!rsp_if.ready) rsp_if.ready = ($urandom_range(0, 2) == 0);
      else rsp_if.ready = ($urandom_range(0, 9) != 0);
   end

   // Check code byte words as they are accepted
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_byte(rsp_if.code_byte, rsp_if.end_of_run, rsp_if.end_of_stream);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold one pixel word until accepted; valid stays high afterwards
   task send_pixel(logic [7:0] pix, bit last);
      @(negedge clock);
      req_if.valid = 1;
      req_if.pixel_index = pix;
      req_if.last_pixel = last;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      sb.note_pixel(pix, last);
      sent_pixels++;
   endtask

   task idle_sender(int n);
      @(negedge clock);
      req_if.valid = 0;
      repeat (n) @(negedge clock);
   endtask

   // Drain every expected byte and wait for the block to be idle, then settle
   task wait_drained();
      @(negedge clock);
      req_if.valid = 0;
      while (sb.pending_bytes.size() != 0 || !req_if.ready) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task write_init_bits(logic [3:0] v);
      wait_drained();
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = glzw_pkg::ADDR_INIT_BITS;
      csr_pwdata = {28'($urandom_range(0, 32'h0fff_ffff)), v};
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      sb.set_init_bits(v);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   // Send one image; alphabet sets the hit rate of the dictionary
   task send_image(int len, int alphabet);
      int         g;
      logic [7:0] pix;
      for (int k = 0; k < len; k++) begin
         g = gap_len();
         if (g > 0) idle_sender(g);
         if ($urandom_range(0, 99) < 15) pix = 8'($urandom_range(0, 255));
         else pix = 8'($urandom_range(0, alphabet - 1));
         send_pixel(pix, k == len - 1);
      end
   endtask

   initial begin
      int          len;
      logic [3:0]  bits_pick;
      logic [3:0]  bit_set[7];
      bit_set = '{4'd0, 4'd3, 4'd4, 4'd8, 4'd9, 4'd15, 4'd2};
      req_if.valid = 0;
      req_if.pixel_index = '0;
      req_if.last_pixel = 0;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: single pixel images, extremes, repeated runs
      send_pixel(8'd255, 1);
      send_pixel(8'd0, 1);
      send_pixel(8'd0, 0);
      repeat (8) send_pixel(8'd0, 0);
      send_pixel(8'd255, 0);
      send_pixel(8'd170, 0);
      send_pixel(8'd85, 1);
      write_init_bits(4'd3);
      send_pixel(8'd7, 0);
      send_pixel(8'd3, 0);
      send_pixel(8'd3, 0);
      send_pixel(8'd3, 1);
      write_init_bits(4'd0);
      send_pixel(8'd1, 0);
      send_pixel(8'd2, 1);
      write_init_bits(4'd15);
      send_pixel(8'd128, 0);
      send_pixel(8'd127, 1);

      // Random images across settings
      while (sent_pixels < 330) begin
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 3) == 0) bits_pick = 4'($urandom_range(0, 15));
            else bits_pick = bit_set[$urandom_range(0, 6)];
            write_init_bits(bits_pick);
         end else if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         case ($urandom_range(0, 3))
            0: send_image(len, 2);
            1: send_image(len, 4);
            2: send_image(len, 16);
            default: send_image(len, 256);
         endcase
      end
      write_init_bits(4'd9);
      send_image(30, 3);

      wait_drained();
      repeat (IDLE_SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== gif_lzw_encoder_unit.f =====
+incdir+src
src/glzw_pkg.sv
src/glzw_if.sv
src/glzw_ram.sv
src/gif_lzw_encoder_unit.sv
src/glzw_checker.sv
verif/tb_top.sv
